### rtl/sprt_pkg.sv
package sprt_pkg;

  // Number of servos on the bus; valid ids are 1..SERVO_COUNT.
  localparam int SERVO_COUNT = 6;
  localparam int CIDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  localparam int PKT_LEN = 8;
  localparam int BEAT_W = $clog2(PKT_LEN);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ID   = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_HEADER   = 3'd3;
  localparam logic [2:0] ST_ID       = 3'd4;
  localparam logic [2:0] ST_LENGTH   = 3'd5;
  localparam logic [2:0] ST_CHECKSUM = 3'd6;
  localparam logic [2:0] ST_SERVO    = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_POS_REG = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Packet constants.
  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] READ_INST = 8'h02;
  localparam logic [7:0] POS_BYTES = 8'h02;
  localparam logic [7:0] LEN_FIELD = 8'h04;

  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  // One unit of work handed from the front end to the back end: either a
  // full read request to serialize, or a single transaction-ending result.
  typedef struct packed {
    logic               is_req;
    logic [7:0]         id;
    logic [7:0]         reg_addr;
    logic [2:0]         status;
    logic signed [15:0] position;
    logic signed [15:0] cached_position;
    logic               cached_valid;
  } job_t;

endpackage

### rtl/sprt_if.sv
interface sprt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] servo_id;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, servo_id, rx_byte, input ready);
  modport sink (input valid, cmd, servo_id, rx_byte, output ready);
endinterface

interface sprt_out_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               done_res;
  logic [2:0]         status;
  logic signed [15:0] position;
  logic signed [15:0] cached_position;
  logic               cached_valid;
  logic               last;

  modport source (output valid, tx_valid, tx_byte, done_res, status, position,
                  cached_position, cached_valid, last, input ready);
  modport sink (input valid, tx_valid, tx_byte, done_res, status, position,
                cached_position, cached_valid, last, output ready);
endinterface

### rtl/sprt_front.sv
module sprt_front import sprt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data,
  sprt_in_if.sink   in_ch,
  input  logic      q_full,
  output logic      push,
  output job_t      push_job
);

  logic [7:0]  pos_reg;
  logic [15:0] timeout;

  logic        busy;
  logic [7:0]  cur_id;
  logic [3:0]  rx_count;
  logic [16:0] elapsed;
  logic [7:0]  rx_buf [PKT_LEN];
  logic [15:0] cache [SERVO_COUNT];
  logic [SERVO_COUNT-1:0] cache_vld;

  logic              accept;
  logic [7:0]        id_m1;
  logic [CIDX_W-1:0] cidx;
  logic [15:0]       cache_rd;
  logic              cache_rd_vld;
  logic              last_byte;
  logic [7:0]        sum;
  logic [2:0]        rx_status;
  logic [15:0]       rx_pos;
  logic [16:0]       elapsed_next;
  logic              expired;
  logic              id_ok;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  assign id_m1 = cur_id - 8'd1;
  assign cidx = id_m1[CIDX_W-1:0];
  assign cache_rd_vld = cache_vld[cidx];
  assign cache_rd = cache_rd_vld ? cache[cidx] : 16'd0;

  assign id_ok = (in_ch.servo_id != 8'd0) && (in_ch.servo_id <= 8'(SERVO_COUNT));

  // The eighth byte arrives as the current input; the first seven are buffered.
  assign last_byte = (rx_count == 4'(PKT_LEN - 1));
  assign sum = rx_buf[2] + rx_buf[3] + rx_buf[4] + rx_buf[5] + rx_buf[6];
  assign rx_pos = {rx_buf[6], rx_buf[5]};

  always_comb begin
    priority if (rx_buf[0] != HDR_BYTE || rx_buf[1] != HDR_BYTE) begin
      rx_status = ST_HEADER;
    end else if (rx_buf[2] != cur_id) begin
      rx_status = ST_ID;
    end else if (rx_buf[3] != LEN_FIELD) begin
      rx_status = ST_LENGTH;
    end else if (in_ch.rx_byte != ~sum) begin
      rx_status = ST_CHECKSUM;
    end else if (rx_buf[4] != 8'd0) begin
      rx_status = ST_SERVO;
    end else begin
      rx_status = ST_OK;
    end
  end

  assign elapsed_next = (elapsed != TICK_MAX) ? elapsed + 17'd1 : elapsed;
  assign expired = elapsed_next > {1'b0, timeout};

  always_comb begin
    push = 1'b0;
    push_job = '0;
    if (accept) begin
      unique case (in_ch.cmd)
        CMD_START: begin
          if (!busy) begin
            push = 1'b1;
            if (id_ok) begin
              push_job.is_req = 1'b1;
              push_job.id = in_ch.servo_id;
              push_job.reg_addr = pos_reg;
            end else begin
              push_job.status = ST_BAD_ID;
            end
          end
        end
        CMD_BYTE: begin
          if (busy && last_byte) begin
            push = 1'b1;
            push_job.status = rx_status;
            if (rx_status == ST_OK) begin
              push_job.position = rx_pos;
              push_job.cached_position = rx_pos;
              push_job.cached_valid = 1'b1;
            end else begin
              push_job.cached_position = cache_rd;
              push_job.cached_valid = cache_rd_vld;
            end
          end
        end
        CMD_TICK: begin
          if (busy && expired) begin
            push = 1'b1;
            push_job.status = ST_TIMEOUT;
            push_job.cached_position = cache_rd;
            push_job.cached_valid = cache_rd_vld;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_reg <= 8'd56;
      timeout <= 16'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_REG: pos_reg <= cfg_data[7:0];
        CFG_TIMEOUT: timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cur_id <= 8'd0;
      rx_count <= 4'd0;
      elapsed <= 17'd0;
      cache_vld <= '0;
    end else if (accept) begin
      unique case (in_ch.cmd)
        CMD_START: begin
          if (!busy && id_ok) begin
            busy <= 1'b1;
            cur_id <= in_ch.servo_id;
            rx_count <= 4'd0;
            elapsed <= 17'd0;
          end
        end
        CMD_BYTE: begin
          if (busy) begin
            if (last_byte) begin
              busy <= 1'b0;
              rx_count <= 4'd0;
              if (rx_status == ST_OK) begin
                cache_vld[cidx] <= 1'b1;
              end
            end else begin
              rx_count <= rx_count + 4'd1;
            end
          end
        end
        CMD_TICK: begin
          if (busy) begin
            elapsed <= elapsed_next;
            if (expired) begin
              busy <= 1'b0;
              rx_count <= 4'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload storage: receive buffer and position cache.
  always_ff @(posedge clk) begin
    if (accept && in_ch.cmd == CMD_BYTE && busy) begin
      rx_buf[rx_count[BEAT_W-1:0]] <= in_ch.rx_byte;
      if (last_byte && rx_status == ST_OK) begin
        cache[cidx] <= rx_pos;
      end
    end
  end

endmodule

### rtl/sprt_fifo.sv
module sprt_fifo import sprt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      unique case ({push, pop})
        2'b10: count <= count + (FIFO_AW+1)'(1);
        2'b01: count <= count - (FIFO_AW+1)'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

### rtl/sprt_back.sv
module sprt_back import sprt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  job_t        head,
  output logic        pop,
  sprt_out_if.source  out_ch
);

  logic [BEAT_W-1:0] beat;
  logic              load;
  logic              last_beat;
  logic [7:0]        chk;
  logic [7:0]        req_byte;

  assign load = !empty && (!out_ch.valid || out_ch.ready);
  assign last_beat = (beat == BEAT_W'(PKT_LEN - 1));
  assign pop = load && (!head.is_req || last_beat);

  assign chk = ~(head.id + LEN_FIELD + READ_INST + head.reg_addr + POS_BYTES);

  always_comb begin
    unique case (beat)
      3'd0, 3'd1: req_byte = HDR_BYTE;
      3'd2: req_byte = head.id;
      3'd3: req_byte = LEN_FIELD;
      3'd4: req_byte = READ_INST;
      3'd5: req_byte = head.reg_addr;
      3'd6: req_byte = POS_BYTES;
      default: req_byte = chk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      beat <= '0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
      if (head.is_req) begin
        beat <= beat + BEAT_W'(1);
      end
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.is_req) begin
        out_ch.tx_valid <= 1'b1;
        out_ch.tx_byte <= req_byte;
        out_ch.done_res <= 1'b0;
        out_ch.status <= ST_OK;
        out_ch.position <= '0;
        out_ch.cached_position <= '0;
        out_ch.cached_valid <= 1'b0;
        out_ch.last <= last_beat;
      end else begin
        out_ch.tx_valid <= 1'b0;
        out_ch.tx_byte <= 8'd0;
        out_ch.done_res <= 1'b1;
        out_ch.status <= head.status;
        out_ch.position <= head.position;
        out_ch.cached_position <= head.cached_position;
        out_ch.cached_valid <= head.cached_valid;
        out_ch.last <= 1'b1;
      end
    end
  end

endmodule

### rtl/servo_position_read_transaction_unit.sv
// Servo position read transaction unit.
// The cmd_ch channel takes one command beat per cycle while ready: a start
// read with a servo id, one received bus byte, or one time tick. The res_ch
// channel gives result beats: eight request bytes to transmit after a good
// start, then one done beat with status, position and the cache entry for
// that servo when the eighth reply byte arrives or the tick count passes the
// timeout register. An idle start with a bad id gives one done beat at once;
// other commands that do not end a transaction give no beat. The front end
// decodes each command in the cycle it is accepted and updates the
// transaction state, so commands are taken back to back, one per cycle while
// the queue has room. Work is queued in a four-entry queue; the back end
// turns it into result beats through an output register, one beat per cycle
// unless the receiver stalls. With the queue empty, a command's beat goes
// through the queue, then the output register. When the receiver stalls,
// the output register holds its beat, the queue fills, and cmd_ch.ready
// drops only once the queue is full. Reset (rst, synchronous) clears the
// transaction state, the cache valid flags, the queue and the output valid,
// and loads the configuration registers with their defaults (register
// address 56, timeout 3000 ticks). The user must write the configuration
// port only while no transaction is in flight; the block does not check it.
module servo_position_read_transaction_unit import sprt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  sprt_in_if.sink     cmd_ch,
  sprt_out_if.source  res_ch
);

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_head;

  // Front end: command decode, reply gathering and checking, cache update.
  sprt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (cmd_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  // Queue that lets the front end run ahead while the back end serializes.
  sprt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_push_job),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  // Back end: request serialization and the output register.
  sprt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (q_head),
    .pop   (q_pop),
    .out_ch(res_ch)
  );

endmodule

### rtl/sprt_checker.sv
module sprt_checker import sprt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               tx_valid,
  input logic [7:0]         tx_byte,
  input logic               done_res,
  input logic [2:0]         status,
  input logic signed [15:0] position,
  input logic signed [15:0] cached_position,
  input logic               cached_valid,
  input logic               last
);

  // A stalled beat stays in place unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(status)
      && $stable(position) && $stable(last))
    else $error("result beat changed while stalled");

  // Request bytes never end a transaction and carry no status.
  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> !done_res && status == ST_OK && !cached_valid)
    else $error("request beat carries done fields");

  // A done beat always closes the command's results.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last && !tx_valid)
    else $error("done beat not marked last");

  // An unset cache entry reads as zero.
  a_cache_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && !cached_valid |-> cached_position == 16'sd0)
    else $error("unset cache entry not zero");

  // A good read is reflected in the cache at once.
  a_ok_cached: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && status == ST_OK |->
      cached_valid && cached_position == position)
    else $error("good read not cached");

endmodule

bind servo_position_read_transaction_unit sprt_checker u_sprt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res_ch.valid),
  .out_ready      (res_ch.ready),
  .tx_valid       (res_ch.tx_valid),
  .tx_byte        (res_ch.tx_byte),
  .done_res       (res_ch.done_res),
  .status         (res_ch.status),
  .position       (res_ch.position),
  .cached_position(res_ch.cached_position),
  .cached_valid   (res_ch.cached_valid),
  .last           (res_ch.last)
);
